// ===== sv/cds_pkg.sv =====
`default_nettype none

package cds_pkg;

  typedef enum logic [2:0] {
    DS_NOT_READY      = 3'd0,
    DS_DISABLED       = 3'd1,
    DS_READY          = 3'd2,
    DS_SWITCHED_ON    = 3'd3,
    DS_ENABLED        = 3'd4,
    DS_QUICKSTOP      = 3'd5,
    DS_FAULT_REACTION = 3'd6,
    DS_FAULT          = 3'd7
  } drive_state_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_HOME_STEP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_DIRECTION = 2'd2;

  localparam logic [CFG_DATA_W-1:0] HOME_STEP_RST = 31'd8389;
  localparam logic [CFG_DATA_W-1:0] MOVE_STEP_RST = 31'd8389;
  localparam logic                  MOVE_DIR_RST  = 1'b1;

  localparam logic [15:0] SW_MASK_A          = 16'h004F;
  localparam logic [15:0] SW_MASK_B          = 16'h006F;
  localparam logic [15:0] SW_NOT_READY       = 16'h0000;
  localparam logic [15:0] SW_DISABLED        = 16'h0040;
  localparam logic [15:0] SW_READY           = 16'h0021;
  localparam logic [15:0] SW_SWITCHED_ON     = 16'h0023;
  localparam logic [15:0] SW_ENABLED         = 16'h0027;
  localparam logic [15:0] SW_QUICKSTOP       = 16'h0007;
  localparam logic [15:0] SW_FAULT_REACTION  = 16'h000F;
  localparam logic [15:0] SW_FAULT           = 16'h0008;

  localparam logic [15:0] CW_DISABLE_VOLTAGE = 16'h0000;
  localparam logic [15:0] CW_FAULT_RESET     = 16'h0080;
  localparam logic [15:0] CW_SHUTDOWN        = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON       = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP       = 16'h000F;

  localparam logic [7:0] MODE_POSITION = 8'd8;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic         state_hit;
    drive_state_e state_code;
    logic         mode_pos;
    logic         req_reset;
    logic         req_quickstop;
    logic         req_power;
    logic         req_home;
    logic [31:0]  actual;
  } cds_item_t;

endpackage

`default_nettype wire

// ===== sv/cds_front.sv =====
`default_nettype none

module cds_front (
  input  var logic              in_valid_i,
  output var logic              in_stall_o,
  input  var logic [15:0]       status_word_i,
  input  var logic [31:0]       actual_position_i,
  input  var logic [7:0]        mode_display_i,
  input  var logic              req_reset_i,
  input  var logic              req_quickstop_i,
  input  var logic              req_power_i,
  input  var logic              req_home_i,
  input  var logic              q_full_i,
  output var logic              q_push_o,
  output cds_pkg::cds_item_t    q_item_o
);

  logic [15:0] masked_a;
  logic [15:0] masked_b;

  assign masked_a = status_word_i & cds_pkg::SW_MASK_A;
  assign masked_b = status_word_i & cds_pkg::SW_MASK_B;

  always_comb begin
    q_item_o.state_hit  = 1'b1;
    q_item_o.state_code = cds_pkg::DS_NOT_READY;
    if (masked_a == cds_pkg::SW_NOT_READY) begin
      q_item_o.state_code = cds_pkg::DS_NOT_READY;
    end else if (masked_a == cds_pkg::SW_DISABLED) begin
      q_item_o.state_code = cds_pkg::DS_DISABLED;
    end else if (masked_b == cds_pkg::SW_READY) begin
      q_item_o.state_code = cds_pkg::DS_READY;
    end else if (masked_b == cds_pkg::SW_SWITCHED_ON) begin
      q_item_o.state_code = cds_pkg::DS_SWITCHED_ON;
    end else if (masked_b == cds_pkg::SW_ENABLED) begin
      q_item_o.state_code = cds_pkg::DS_ENABLED;
    end else if (masked_b == cds_pkg::SW_QUICKSTOP) begin
      q_item_o.state_code = cds_pkg::DS_QUICKSTOP;
    end else if (masked_a == cds_pkg::SW_FAULT_REACTION) begin
      q_item_o.state_code = cds_pkg::DS_FAULT_REACTION;
    end else if (masked_a == cds_pkg::SW_FAULT) begin
      q_item_o.state_code = cds_pkg::DS_FAULT;
    end else begin
      q_item_o.state_hit = 1'b0;
    end
    q_item_o.mode_pos      = (mode_display_i == cds_pkg::MODE_POSITION);
    q_item_o.req_reset     = req_reset_i;
    q_item_o.req_quickstop = req_quickstop_i;
    q_item_o.req_power     = req_power_i;
    q_item_o.req_home      = req_home_i;
    q_item_o.actual        = actual_position_i;
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

endmodule

`default_nettype wire

// ===== sv/cds_queue.sv =====
`default_nettype none

module cds_queue (
  input  var logic               clk_i,
  input  var logic               rst_ni,
  input  var logic               push_i,
  input  cds_pkg::cds_item_t     push_item_i,
  output var logic               full_o,
  output var logic               valid_o,
  input  var logic               pop_i,
  output cds_pkg::cds_item_t     pop_item_o
);

  localparam int unsigned PtrW = (cds_pkg::QUEUE_DEPTH > 1) ? $clog2(cds_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(cds_pkg::QUEUE_DEPTH + 1);

  cds_pkg::cds_item_t mem_q [cds_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (count_q == CntW'(cds_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i & ~full_o;
  assign do_pop     = pop_i & valid_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(cds_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(cds_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cds_back.sv =====
`default_nettype none

module cds_back #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  var logic                            clk_i,
  input  var logic                            rst_ni,
  input  var logic                            cfg_we_i,
  input  var logic [cds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  var logic [cds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  var logic                            q_valid_i,
  input  cds_pkg::cds_item_t                  q_item_i,
  output var logic                            q_pop_o,
  output var logic                            out_valid_o,
  input  var logic                            out_stall_i,
  output var logic [15:0]                     ctrl_word_o,
  output var logic                            ctrl_write_o,
  output var logic [7:0]                      mode_out_o,
  output var logic                            mode_write_o,
  output var logic [31:0]                     target_out_o,
  output var logic                            target_write_o,
  output var logic [2:0]                      state_out_o,
  output var logic                            homing_active_o,
  output var logic                            move_active_o
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned CW = (POSITION_WIDTH > 32) ? POSITION_WIDTH : 32;

  logic [cds_pkg::CFG_DATA_W-1:0] home_step_q;
  logic [cds_pkg::CFG_DATA_W-1:0] move_step_q;
  logic                           move_dir_q;

  cds_pkg::drive_state_e state_q, state_d;
  logic          reset_pend_q, reset_pend_d;
  logic          qs_pend_q, qs_pend_d;
  logic          power_pend_q, power_pend_d;
  logic          home_pend_q, home_pend_d;
  logic          move_en_q, move_en_d;
  logic          origin_need_q, origin_need_d;
  logic [PW-1:0] origin_q, origin_d;
  logic [PW-1:0] target_q, target_d;

  logic          out_valid_q, out_valid_d;
  logic [15:0]   ctrl_d;
  logic          ctrl_wr_d;
  logic          mode_wr_d;
  logic          tgt_wr_d;
  logic [CW-1:0] tgt_ext;

  logic                 pop;
  logic signed [CW-1:0] act_ext;
  logic [PW-1:0]        act;
  logic [PW-1:0]        span;
  logic [CW-1:0]        wide_sum;

  assign pop     = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_step_q <= cds_pkg::HOME_STEP_RST;
      move_step_q <= cds_pkg::MOVE_STEP_RST;
      move_dir_q  <= cds_pkg::MOVE_DIR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cds_pkg::CFG_HOME_STEP:      home_step_q <= cfg_data_i;
        cds_pkg::CFG_MOVE_STEP:      move_step_q <= cfg_data_i;
        cds_pkg::CFG_MOVE_DIRECTION: move_dir_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // next drive state: keep the last one when no pattern matched
  always_comb begin
    state_d = state_q;
    if (q_item_i.state_hit) begin
      state_d = q_item_i.state_code;
    end
  end

  always_comb begin
    act_ext       = CW'($signed(q_item_i.actual));
    act           = act_ext[PW-1:0];
    reset_pend_d  = reset_pend_q | q_item_i.req_reset;
    qs_pend_d     = qs_pend_q | q_item_i.req_quickstop;
    power_pend_d  = power_pend_q | q_item_i.req_power;
    home_pend_d   = home_pend_q | q_item_i.req_home;
    move_en_d     = move_en_q;
    origin_need_d = origin_need_q;
    origin_d      = origin_q;
    target_d      = target_q;
    ctrl_d        = cds_pkg::CW_DISABLE_VOLTAGE;
    ctrl_wr_d     = 1'b0;
    mode_wr_d     = 1'b0;
    tgt_wr_d      = 1'b0;
    span          = '0;
    wide_sum      = '0;

    if (state_d == cds_pkg::DS_ENABLED && origin_need_q) begin
      origin_d      = act;
      origin_need_d = 1'b0;
    end

    if (reset_pend_d) begin
      case (state_d)
        cds_pkg::DS_READY, cds_pkg::DS_SWITCHED_ON, cds_pkg::DS_ENABLED: begin
          ctrl_d    = cds_pkg::CW_DISABLE_VOLTAGE;
          ctrl_wr_d = 1'b1;
        end
        cds_pkg::DS_FAULT_REACTION, cds_pkg::DS_FAULT: begin
          ctrl_d    = cds_pkg::CW_FAULT_RESET;
          ctrl_wr_d = 1'b1;
        end
        cds_pkg::DS_DISABLED: reset_pend_d = 1'b0;
        default: ;
      endcase
    end else if (qs_pend_d) begin
      case (state_d)
        cds_pkg::DS_READY, cds_pkg::DS_SWITCHED_ON, cds_pkg::DS_ENABLED: begin
          ctrl_d    = cds_pkg::CW_DISABLE_VOLTAGE;
          ctrl_wr_d = 1'b1;
        end
        default: begin
          qs_pend_d = 1'b0;
          move_en_d = 1'b0;
        end
      endcase
    end else if (power_pend_d) begin
      case (state_d)
        cds_pkg::DS_DISABLED: begin
          mode_wr_d = 1'b1;
          ctrl_d    = cds_pkg::CW_SHUTDOWN;
          ctrl_wr_d = 1'b1;
        end
        cds_pkg::DS_READY: begin
          mode_wr_d = 1'b1;
          ctrl_d    = cds_pkg::CW_SWITCH_ON;
          ctrl_wr_d = 1'b1;
        end
        cds_pkg::DS_SWITCHED_ON: begin
          mode_wr_d = 1'b1;
          ctrl_d    = cds_pkg::CW_ENABLE_OP;
          ctrl_wr_d = 1'b1;
          target_d  = act;
          tgt_wr_d  = 1'b1;
        end
        cds_pkg::DS_ENABLED: begin
          power_pend_d = 1'b0;
          move_en_d    = 1'b1;
        end
        default: ;
      endcase
    end

    if (state_d == cds_pkg::DS_ENABLED && !reset_pend_d && !power_pend_d && !qs_pend_d
        && q_item_i.mode_pos) begin
      if (home_pend_d) begin
        if ($signed(act) > $signed(origin_d)) begin
          span     = act - origin_d;
          wide_sum = CW'(act) - CW'(home_step_q);
          target_d = (CW'(span) <= CW'(home_step_q)) ? origin_d : wide_sum[PW-1:0];
        end else if ($signed(origin_d) > $signed(act)) begin
          span     = origin_d - act;
          wide_sum = CW'(act) + CW'(home_step_q);
          target_d = (CW'(span) <= CW'(home_step_q)) ? origin_d : wide_sum[PW-1:0];
        end else begin
          target_d    = origin_d;
          home_pend_d = 1'b0;
          move_en_d   = 1'b0;
        end
      end else if (move_en_d) begin
        if (move_dir_q) begin
          wide_sum = CW'(target_q) + CW'(move_step_q);
        end else begin
          wide_sum = CW'(target_q) - CW'(move_step_q);
        end
        target_d = wide_sum[PW-1:0];
      end else begin
        target_d = act;
      end
      tgt_wr_d = 1'b1;
    end

    tgt_ext = CW'(target_d);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= cds_pkg::DS_NOT_READY;
      reset_pend_q  <= 1'b0;
      qs_pend_q     <= 1'b0;
      power_pend_q  <= 1'b0;
      home_pend_q   <= 1'b0;
      move_en_q     <= 1'b0;
      origin_need_q <= 1'b1;
      origin_q      <= '0;
      target_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        state_q       <= state_d;
        reset_pend_q  <= reset_pend_d;
        qs_pend_q     <= qs_pend_d;
        power_pend_q  <= power_pend_d;
        home_pend_q   <= home_pend_d;
        move_en_q     <= move_en_d;
        origin_need_q <= origin_need_d;
        origin_q      <= origin_d;
        target_q      <= target_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ctrl_word_o     <= ctrl_d;
      ctrl_write_o    <= ctrl_wr_d;
      mode_out_o      <= cds_pkg::MODE_POSITION;
      mode_write_o    <= mode_wr_d;
      target_out_o    <= tgt_ext[31:0];
      target_write_o  <= tgt_wr_d;
      state_out_o     <= state_d;
      homing_active_o <= home_pend_d;
      move_active_o   <= move_en_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_ctrl_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ctrl_write_o |-> ctrl_word_o == cds_pkg::CW_DISABLE_VOLTAGE)
    else $error("control word not zero without write");

  a_mode_with_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_write_o |-> ctrl_write_o)
    else $error("mode write without control word write");

  a_target_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_write_o && !mode_write_o
      |-> state_out_o == cds_pkg::DS_ENABLED)
    else $error("target driven outside enabled state");

  a_fault_reset_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ctrl_write_o && ctrl_word_o == cds_pkg::CW_FAULT_RESET
      |-> state_out_o == cds_pkg::DS_FAULT_REACTION || state_out_o == cds_pkg::DS_FAULT)
    else $error("fault reset sent outside fault states");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> !$past(pop))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== sv/cia402_drive_sequencer.sv =====
// Drive sequencer for a CiA 402 servo drive. Takes one transaction per clock unless stalled:
// the status word is decoded into the drive state, pending reset, quick stop and power-on
// requests are served in that priority through the control word and mode write, and in
// position mode the target homes toward the origin captured on the first enabled transaction,
// ramps by the configured step or else follows the actual position. The rate is set by the
// state update in the back end; a result is registered in a queue entry, then in the back
// end's output register. The two-entry queue between decode and execution lets either side
// stall on its own. The homing step (index 0), move step (1) and move direction (2) registers
// must be set by the user via the config port while no transaction is in flight; unenforced.
`default_nettype none

module cia402_drive_sequencer #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  var logic                            clk_i,
  input  var logic                            rst_ni,
  input  var logic                            cfg_we_i,
  input  var logic [cds_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  var logic [cds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  var logic                            in_valid_i,
  output var logic                            in_stall_o,
  input  var logic [15:0]                     status_word_i,
  input  var logic signed [31:0]              actual_position_i,
  input  var logic [7:0]                      mode_display_i,
  input  var logic                            req_reset_i,
  input  var logic                            req_quickstop_i,
  input  var logic                            req_power_i,
  input  var logic                            req_home_i,
  output var logic                            out_valid_o,
  input  var logic                            out_stall_i,
  output var logic [15:0]                     ctrl_word_o,
  output var logic                            ctrl_write_o,
  output var logic [7:0]                      mode_out_o,
  output var logic                            mode_write_o,
  output var logic signed [31:0]              target_out_o,
  output var logic                            target_write_o,
  output var logic [2:0]                      state_out_o,
  output var logic                            homing_active_o,
  output var logic                            move_active_o
);

  cds_pkg::cds_item_t push_item;
  cds_pkg::cds_item_t pop_item;
  logic               q_full;
  logic               q_push;
  logic               q_valid;
  logic               q_pop;
  logic [31:0]        target_raw;

  cds_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .status_word_i     (status_word_i),
    .actual_position_i (actual_position_i),
    .mode_display_i    (mode_display_i),
    .req_reset_i       (req_reset_i),
    .req_quickstop_i   (req_quickstop_i),
    .req_power_i       (req_power_i),
    .req_home_i        (req_home_i),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_item_o          (push_item)
  );

  cds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item)
  );

  cds_back #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .q_valid_i       (q_valid),
    .q_item_i        (pop_item),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .ctrl_word_o     (ctrl_word_o),
    .ctrl_write_o    (ctrl_write_o),
    .mode_out_o      (mode_out_o),
    .mode_write_o    (mode_write_o),
    .target_out_o    (target_raw),
    .target_write_o  (target_write_o),
    .state_out_o     (state_out_o),
    .homing_active_o (homing_active_o),
    .move_active_o   (move_active_o)
  );

  assign target_out_o = $signed(target_raw);

endmodule

`default_nettype wire
